[src/pacu_pkg.sv]
package pacu_pkg;

  // Default sample width, signed Q2.13 at 16 bits.
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Subcarrier layout of one OFDM symbol.
  localparam int NUM_SUBCARRIERS = 52;
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] IDX_LAST = 6'(NUM_SUBCARRIERS - 1);
  localparam logic [IDX_W-1:0] PILOT_A = 6'd6;
  localparam logic [IDX_W-1:0] PILOT_B = 6'd20;
  localparam logic [IDX_W-1:0] PILOT_C = 6'd31;
  localparam logic [IDX_W-1:0] PILOT_NEG = 6'd45;

  // 1/sqrt(2) as unsigned Q0.16, carried in a signed 18-bit constant.
  localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;
  localparam int ROUND_SHIFT = 16;

  // Two-bit sign codes of the decision outputs.
  localparam logic [1:0] SIGN_POS = 2'b01;
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_NEG = 2'b11;

endpackage

[src/pilot_aided_channel_update_top.sv]
// Pilot-aided channel update: one subcarrier item in, one result item out.
// Six register stages, stages 1 to 5 and the output stage, lie between the accepting edge and out_valid.
// Throughput: one item per cycle; the whole pipeline advances together whenever
// the output register is empty or its item is being taken.
// Reset (rst, synchronous): clears all stage valid bits and the subcarrier index to 0.
module pilot_aided_channel_update_top #(
  parameter int SAMPLE_WIDTH = pacu_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] rx_re,
  input  logic signed [SAMPLE_WIDTH-1:0] rx_im,
  input  logic signed [SAMPLE_WIDTH-1:0] est_re,
  input  logic signed [SAMPLE_WIDTH-1:0] est_im,
  input  logic signed [SAMPLE_WIDTH-1:0] prior_re,
  input  logic signed [SAMPLE_WIDTH-1:0] prior_im,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] avg_re,
  output logic signed [SAMPLE_WIDTH-1:0] avg_im,
  output logic signed [SAMPLE_WIDTH-1:0] ls_re,
  output logic signed [SAMPLE_WIDTH-1:0] ls_im,
  output logic        [1:0]              dec_re_sign,
  output logic        [1:0]              dec_im_sign,
  output logic                           last_subcarrier
);
  import pacu_pkg::*;

  localparam int W = SAMPLE_WIDTH;
  // Width of the scaled LS product: (W+2)-bit operand times an 18-bit constant.
  localparam int MW = W + 20;
  // Width after the rounding shift; wide enough to see overflow before saturation.
  localparam int RW = MW - ROUND_SHIFT;

  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [RW-1:0] R_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [MW-1:0] ROUND_HALF = MW'(1) <<< (ROUND_SHIFT - 1);

  // The pipeline moves as one: every stage loads when the output stage can load.
  logic adv;
  logic in_acc;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_acc = in_valid && in_ready;

  // Subcarrier index, advanced once per accepted item, wrapping after the last one.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  assign idx_next = (idx >= IDX_LAST) ? '0 : idx + 1'b1;

  logic cur_pilot;
  logic cur_neg;
  assign cur_neg = (idx == PILOT_NEG);
  assign cur_pilot = (idx == PILOT_A) || (idx == PILOT_B) || (idx == PILOT_C) || cur_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (in_acc) begin
      idx <= idx_next;
    end
  end

  // Stage 1: the four cross products of rx and est.
  logic                    v1;
  logic signed [W-1:0]     rr1, ri1, pr1, pi1;
  logic                    pilot1, neg1, last1;
  logic signed [2*W-1:0]   rr_er1, ri_ei1, ri_er1, rr_ei1;

  // Stage 2: decision signs taken from rx * conj(est).
  logic                    v2;
  logic signed [W-1:0]     rr2, ri2, pr2, pi2;
  logic                    pilot2, neg2, last2;
  logic                    sr_neg2, si_neg2;

  // Stage 3: rx * conj(s) on data, negated or passed rx on pilots.
  // The sum of two full-scale terms can reach 2^W, so it needs W+2 bits.
  logic                    v3;
  logic signed [W+1:0]     a3, b3;
  logic signed [W-1:0]     pl_re3, pl_im3, pr3, pi3;
  logic                    pilot3, last3;
  logic [1:0]              sgn_re3, sgn_im3;

  // Stage 4: scale by 1/sqrt(2).
  logic                    v4;
  logic signed [MW-1:0]    m_re4, m_im4;
  logic signed [W-1:0]     pl_re4, pl_im4, pr4, pi4;
  logic                    pilot4, last4;
  logic [1:0]              sgn_re4, sgn_im4;

  // Stage 5: round, saturate and pick the LS estimate.
  logic                    v5;
  logic signed [W-1:0]     ls_re5, ls_im5, pr5, pi5;
  logic                    last5;
  logic [1:0]              sgn_re5, sgn_im5;

  // Combinational values between stages.
  logic signed [2*W:0]     p_re, p_im;
  logic signed [W:0]       rr_x, ri_x, ri_y, rr_y;
  logic signed [W-1:0]     neg_rr, neg_ri;
  logic signed [MW-1:0]    rnd_re, rnd_im;
  logic signed [RW-1:0]    sh_re, sh_im;
  logic signed [W-1:0]     sat_re, sat_im;
  logic signed [W:0]       sum_re, sum_im;

  assign p_re = (2*W+1)'(rr_er1) + (2*W+1)'(ri_ei1);
  assign p_im = (2*W+1)'(ri_er1) - (2*W+1)'(rr_ei1);

  // A zero decision product counts as non-negative, so only the sign bit matters.
  assign rr_x = sr_neg2 ? -(W+1)'(rr2) : (W+1)'(rr2);
  assign ri_x = si_neg2 ? -(W+1)'(ri2) : (W+1)'(ri2);
  assign ri_y = sr_neg2 ? -(W+1)'(ri2) : (W+1)'(ri2);
  assign rr_y = si_neg2 ? -(W+1)'(rr2) : (W+1)'(rr2);

  // Negating full-scale negative saturates to full-scale positive.
  assign neg_rr = (rr2 == S_MIN) ? S_MAX : -rr2;
  assign neg_ri = (ri2 == S_MIN) ? S_MAX : -ri2;

  // Round half up, then an arithmetic shift gives the floor.
  assign rnd_re = m_re4 + ROUND_HALF;
  assign rnd_im = m_im4 + ROUND_HALF;
  assign sh_re = rnd_re[MW-1:ROUND_SHIFT];
  assign sh_im = rnd_im[MW-1:ROUND_SHIFT];
  assign sat_re = (sh_re > R_MAX) ? S_MAX : (sh_re < R_MIN) ? S_MIN : sh_re[W-1:0];
  assign sat_im = (sh_im > R_MAX) ? S_MAX : (sh_im < R_MIN) ? S_MIN : sh_im[W-1:0];

  // The average always fits after halving.
  assign sum_re = (W+1)'(ls_re5) + (W+1)'(pr5);
  assign sum_im = (W+1)'(ls_im5) + (W+1)'(pi5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1
      rr1 <= rx_re;
      ri1 <= rx_im;
      pr1 <= prior_re;
      pi1 <= prior_im;
      pilot1 <= cur_pilot;
      neg1 <= cur_neg;
      last1 <= (idx == IDX_LAST);
      rr_er1 <= rx_re * est_re;
      ri_ei1 <= rx_im * est_im;
      ri_er1 <= rx_im * est_re;
      rr_ei1 <= rx_re * est_im;

      // Stage 2
      rr2 <= rr1;
      ri2 <= ri1;
      pr2 <= pr1;
      pi2 <= pi1;
      pilot2 <= pilot1;
      neg2 <= neg1;
      last2 <= last1;
      sr_neg2 <= p_re[2*W];
      si_neg2 <= p_im[2*W];

      // Stage 3
      a3 <= (W+2)'(rr_x) + (W+2)'(ri_x);
      b3 <= (W+2)'(ri_y) - (W+2)'(rr_y);
      pl_re3 <= neg2 ? neg_rr : rr2;
      pl_im3 <= neg2 ? neg_ri : ri2;
      pr3 <= pr2;
      pi3 <= pi2;
      pilot3 <= pilot2;
      last3 <= last2;
      if (pilot2) begin
        sgn_re3 <= neg2 ? SIGN_NEG : SIGN_POS;
        sgn_im3 <= SIGN_ZERO;
      end else begin
        sgn_re3 <= sr_neg2 ? SIGN_NEG : SIGN_POS;
        sgn_im3 <= si_neg2 ? SIGN_NEG : SIGN_POS;
      end

      // Stage 4
      m_re4 <= MW'(a3) * MW'(INV_SQRT2_Q16);
      m_im4 <= MW'(b3) * MW'(INV_SQRT2_Q16);
      pl_re4 <= pl_re3;
      pl_im4 <= pl_im3;
      pr4 <= pr3;
      pi4 <= pi3;
      pilot4 <= pilot3;
      last4 <= last3;
      sgn_re4 <= sgn_re3;
      sgn_im4 <= sgn_im3;

      // Stage 5
      ls_re5 <= pilot4 ? pl_re4 : sat_re;
      ls_im5 <= pilot4 ? pl_im4 : sat_im;
      pr5 <= pr4;
      pi5 <= pi4;
      last5 <= last4;
      sgn_re5 <= sgn_re4;
      sgn_im5 <= sgn_im4;

      // Output stage
      avg_re <= sum_re[W:1];
      avg_im <= sum_im[W:1];
      ls_re <= ls_re5;
      ls_im <= ls_im5;
      dec_re_sign <= sgn_re5;
      dec_im_sign <= sgn_im5;
      last_subcarrier <= last5;
    end
  end

endmodule
